@@ src/mdpi_pkg.sv @@
// Shared types, codes and constants of the marker dot pattern identifier.
package mdpi_pkg;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_BLOB  = 2'd2,
    REQ_IDENT = 2'd3
  } req_type_t;

  // Blob color codes.
  localparam logic [1:0] COLOR_CENTER = 2'd0;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_COUNT = 2'd1;

  localparam int RADIUS_W = 25;
  localparam int PCOUNT_W = 5;
  localparam logic [RADIUS_W-1:0] RADIUS_SQ_RESET = 25'd1000000;

  // Pattern table entry fields.
  localparam int PLEN_W   = 4;
  localparam int PCOLOR_W = 16;
  localparam int PIDX_W   = 4;
  localparam int PAT_W    = PLEN_W + PCOLOR_W;
  localparam int PAT_DOTS = PCOLOR_W / 2;

  // Arctangent rotation engine.
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = 5;
  localparam int CORDIC_SHIFT = 16;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] atan_val(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

@@ src/mdpi_req_if.sv @@
// Request channel: valid, ready and one request word.
interface mdpi_req_if #(parameter int COORD_BITS = 12);
  import mdpi_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic signed [COORD_BITS-1:0]  blob_x;
  logic signed [COORD_BITS-1:0]  blob_y;
  logic [1:0]                    blob_color;
  logic [PIDX_W-1:0]             pattern_index;
  logic [PLEN_W-1:0]             pattern_length;
  logic [PCOLOR_W-1:0]           pattern_colors;
  modport source (output valid, req_type, blob_x, blob_y, blob_color, pattern_index,
                  pattern_length, pattern_colors, input ready);
  modport sink (input valid, req_type, blob_x, blob_y, blob_color, pattern_index,
                pattern_length, pattern_colors, output ready);
endinterface

@@ src/mdpi_rsp_if.sv @@
// Response channel: valid, ready and one result word.
interface mdpi_rsp_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [3:0] pattern_id;
  logic [3:0] dot_count;
  logic       overflow;
  modport source (output valid, matched, pattern_id, dot_count, overflow, input ready);
  modport sink (input valid, matched, pattern_id, dot_count, overflow, output ready);
endinterface

@@ src/mdpi_cfg_if.sv @@
// Configuration write channel: valid, ready, register index and data.
interface mdpi_cfg_if;
  import mdpi_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/marker_dot_pattern_identifier_top.sv @@
// Marker dot pattern identifier: collects blobs around a center and matches their pattern.
//
// Load and start words are done on acceptance, a blob word in a square and a
// compare state. An identify word reads each kept dot from the dot memory,
// runs one 30-step arctangent rotation per non-center dot with a nonzero
// vector (one step a cycle), sorts it into a register list, scans the angle
// gaps, rotates the list and then reads and checks the pattern memory one
// entry at a time. One word is in work at a time; a finished result waits
// in the output register while the next word is taken.
module marker_dot_pattern_identifier_top
  import mdpi_pkg::*;
#(
  parameter int MAX_DOTS     = 8,
  parameter int MAX_PATTERNS = 16,
  parameter int COORD_BITS   = 12,
  parameter int ANGLE_BITS   = 16
) (
  input logic         clk,
  input logic         rst,
  mdpi_req_if.sink    req,
  mdpi_rsp_if.source  rsp,
  mdpi_cfg_if.sink    cfg
);
  localparam int CNT_W  = $clog2(MAX_DOTS + 1);
  localparam int DI_W   = $clog2(MAX_DOTS);
  localparam int PI_W   = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int PK_W   = $clog2(MAX_PATTERNS + 1);
  localparam int LIM_W  = (PK_W > PCOUNT_W) ? PK_W : PCOUNT_W;
  localparam int S_W    = COORD_BITS + CNT_W + 1;
  localparam int V_W    = COORD_BITS + CNT_W + 2;
  localparam int W      = V_W + CORDIC_SHIFT + 3;
  localparam int SQ_W   = 2 * COORD_BITS + 2;
  localparam int D_W    = (SQ_W + 1 > RADIUS_W) ? SQ_W + 1 : RADIUS_W;
  localparam int DOT_W  = 2 * COORD_BITS + 2;
  localparam int CMP_N  = (MAX_DOTS < PAT_DOTS) ? MAX_DOTS : PAT_DOTS;

  typedef enum logic [3:0] {
    S_IDLE, S_BL_MUL, S_BL_CMP, S_ID_RD, S_ID_VEC, S_ID_PRE, S_ID_ROT, S_ID_INS,
    S_GP_INIT, S_GP_RUN, S_RT, S_PM_RD, S_PM_CHK, S_DONE
  } state_t;

  state_t state;

  // Configuration and marker state.
  logic [RADIUS_W-1:0]          radius_sq;
  logic [PCOUNT_W-1:0]          pattern_count;
  logic [CNT_W-1:0]             kept_count;
  logic signed [S_W-1:0]        sum_x, sum_y;
  logic signed [COORD_BITS-1:0] center_x, center_y;
  logic                         overflow_flag;

  // Captured blob word and distance terms.
  logic signed [COORD_BITS-1:0] bx, by;
  logic [1:0]                   bcolor;
  logic [SQ_W-1:0]              dsq_x, dsq_y;

  // Identify working registers.
  logic [CNT_W-1:0]             k, m, gj, gi, best, rc;
  logic signed [V_W-1:0]        vx, vy;
  logic [1:0]                   cur_color;
  logic signed [W-1:0]          cx, cy;
  logic [31:0]                  acc;
  logic [STEP_W-1:0]            step;
  logic [ANGLE_BITS-1:0]        ang [MAX_DOTS];
  logic [1:0]                   col [MAX_DOTS];
  logic [ANGLE_BITS-1:0]        prev_ang, wide_gap;
  logic [PK_W-1:0]              pk;
  logic                         found;
  logic [PIDX_W-1:0]            found_id;

  // Output register.
  logic                         out_valid;
  logic                         out_matched;
  logic [3:0]                   out_id;
  logic [3:0]                   out_count;
  logic                         out_ovf;

  // Memories.
  logic                    dot_we;
  logic [DI_W-1:0]         dot_waddr, dot_raddr;
  logic [DOT_W-1:0]        dot_wdata, dot_rdata;
  logic                    pat_we;
  logic [PI_W-1:0]         pat_waddr, pat_raddr;
  logic [PAT_W-1:0]        pat_wdata, pat_rdata;

  mdpi_ram #(.WIDTH(DOT_W), .DEPTH(MAX_DOTS), .AW(DI_W)) u_dot_ram (
    .clk(clk), .we(dot_we), .waddr(dot_waddr), .wdata(dot_wdata),
    .raddr(dot_raddr), .rdata(dot_rdata)
  );

  mdpi_ram #(.WIDTH(PAT_W), .DEPTH(MAX_PATTERNS), .AW(PI_W)) u_pat_ram (
    .clk(clk), .we(pat_we), .waddr(pat_waddr), .wdata(pat_wdata),
    .raddr(pat_raddr), .rdata(pat_rdata)
  );

  logic req_acc;
  assign req_acc   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid      = out_valid;
  assign rsp.matched    = out_matched;
  assign rsp.pattern_id = out_id;
  assign rsp.dot_count  = out_count;
  assign rsp.overflow   = out_ovf;

  // Load words with an index below MAX_PATTERNS go straight into the pattern memory.
  assign pat_we    = req_acc && (req_type_t'(req.req_type) == REQ_LOAD) &&
                     (32'(req.pattern_index) < MAX_PATTERNS);
  assign pat_waddr = PI_W'(req.pattern_index);
  assign pat_wdata = {req.pattern_length, req.pattern_colors};
  assign pat_raddr = PI_W'(pk);

  // Distance test and dot write.
  logic [D_W-1:0] dist_sq;
  logic           in_radius;
  assign dist_sq   = D_W'(dsq_x) + D_W'(dsq_y);
  assign in_radius = dist_sq <= D_W'(radius_sq);
  assign dot_we    = (state == S_BL_CMP) && in_radius && (32'(kept_count) < MAX_DOTS);
  assign dot_waddr = DI_W'(kept_count);
  assign dot_wdata = {bcolor, by, bx};
  assign dot_raddr = DI_W'(k);

  // Dot word fields.
  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  logic [1:0]                   rd_color;
  assign rd_x     = dot_rdata[COORD_BITS-1:0];
  assign rd_y     = dot_rdata[2*COORD_BITS-1:COORD_BITS];
  assign rd_color = dot_rdata[DOT_W-1 -: 2];

  // Vector from the mean: n*p - sum(p).
  logic signed [V_W-1:0] n_s, vx_c, vy_c;
  assign n_s  = $signed(V_W'(kept_count));
  assign vx_c = V_W'(n_s * V_W'(rd_x)) - V_W'(sum_x);
  assign vy_c = V_W'(n_s * V_W'(rd_y)) - V_W'(sum_y);

  // Rotation start: scale up and fold into the right half plane.
  logic signed [W-1:0] sx, sy;
  assign sx = W'(vx) <<< CORDIC_SHIFT;
  assign sy = W'(vy) <<< CORDIC_SHIFT;

  // One rotation step.
  logic signed [W-1:0] shx, shy;
  assign shx = cx >>> step;
  assign shy = cy >>> step;

  // Rounded binary angle.
  logic [31:0]           acc_rnd;
  logic [ANGLE_BITS-1:0] new_ang;
  assign acc_rnd = acc + (32'd1 << (31 - ANGLE_BITS));
  assign new_ang = acc_rnd[31 -: ANGLE_BITS];

  // Sorted insert: later arrivals go after equal angles.
  logic [ANGLE_BITS-1:0] ang_ins [MAX_DOTS];
  logic [1:0]            col_ins [MAX_DOTS];
  always_comb begin
    logic [MAX_DOTS-1:0] gt;
    for (int j = 0; j < MAX_DOTS; j++) begin
      gt[j] = (j < 32'(m)) && (ang[j] > new_ang);
    end
    for (int j = 0; j < MAX_DOTS; j++) begin
      if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
        ang_ins[j] = ang[(j > 0) ? j - 1 : 0];
        col_ins[j] = col[(j > 0) ? j - 1 : 0];
      end else if (j <= 32'(m) && (j == 32'(m) || gt[j])) begin
        ang_ins[j] = new_ang;
        col_ins[j] = cur_color;
      end else begin
        ang_ins[j] = ang[j];
        col_ins[j] = col[j];
      end
    end
  end

  // Gap scan read and gap size.
  logic [ANGLE_BITS-1:0] gap_ang, gap;
  assign gap_ang = ang[DI_W'(gj)];
  assign gap     = gap_ang - prev_ang;

  // Pattern compare against the rotated color list.
  logic [LIM_W-1:0] limit;
  logic             pat_ok;
  assign limit = (32'(pattern_count) < MAX_PATTERNS) ? LIM_W'(pattern_count) :
                 LIM_W'(MAX_PATTERNS);
  always_comb begin
    logic [PLEN_W-1:0] len;
    len    = pat_rdata[PAT_W-1 -: PLEN_W];
    pat_ok = (32'(len) == 32'(m)) && (32'(len) <= PAT_DOTS);
    for (int j = 0; j < CMP_N; j++) begin
      if (j < 32'(m) && pat_rdata[2*j +: 2] != col[j]) begin
        pat_ok = 1'b0;
      end
    end
  end

  // Sequencer, state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      radius_sq     <= RADIUS_SQ_RESET;
      pattern_count <= '0;
      kept_count    <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      center_x      <= '0;
      center_y      <= '0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // A result leaving in the cycle of a new one is replaced in S_DONE.
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_RADIUS_SQ) begin
          radius_sq <= cfg.data[RADIUS_W-1:0];
        end else if (cfg.index == CFG_PATTERN_COUNT) begin
          pattern_count <= cfg.data[PCOUNT_W-1:0];
        end
      end
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            bx     <= req.blob_x;
            by     <= req.blob_y;
            bcolor <= req.blob_color;
            case (req_type_t'(req.req_type))
              REQ_START: begin
                center_x      <= req.blob_x;
                center_y      <= req.blob_y;
                kept_count    <= '0;
                sum_x         <= '0;
                sum_y         <= '0;
                overflow_flag <= 1'b0;
              end
              REQ_BLOB:  state <= S_BL_MUL;
              REQ_IDENT: begin
                k        <= '0;
                m        <= '0;
                best     <= '0;
                wide_gap <= '0;
                found    <= 1'b0;
                found_id <= '0;
                state    <= S_ID_RD;
              end
              default: ;
            endcase
          end
        end
        S_BL_MUL: begin
          dsq_x <= SQ_W'((COORD_BITS+1)'(bx) - (COORD_BITS+1)'(center_x)) *
                   SQ_W'((COORD_BITS+1)'(bx) - (COORD_BITS+1)'(center_x));
          dsq_y <= SQ_W'((COORD_BITS+1)'(by) - (COORD_BITS+1)'(center_y)) *
                   SQ_W'((COORD_BITS+1)'(by) - (COORD_BITS+1)'(center_y));
          state <= S_BL_CMP;
        end
        S_BL_CMP: begin
          if (in_radius) begin
            if (32'(kept_count) < MAX_DOTS) begin
              kept_count <= kept_count + 1'b1;
              sum_x      <= sum_x + S_W'(bx);
              sum_y      <= sum_y + S_W'(by);
            end else begin
              overflow_flag <= 1'b1;
            end
          end
          state <= S_IDLE;
        end
        S_ID_RD: begin
          if (k >= kept_count) begin
            state <= (m == '0) ? S_PM_RD : S_GP_INIT;
            pk    <= '0;
          end else begin
            state <= S_ID_VEC;
          end
        end
        S_ID_VEC: begin
          if (rd_color == COLOR_CENTER) begin
            k     <= k + 1'b1;
            state <= S_ID_RD;
          end else begin
            vx        <= vx_c;
            vy        <= vy_c;
            cur_color <= rd_color;
            state     <= S_ID_PRE;
          end
        end
        S_ID_PRE: begin
          step <= '0;
          if (vx == '0 && vy == '0) begin
            acc   <= 32'h0 - (32'd1 << (31 - ANGLE_BITS));
            state <= S_ID_INS;
          end else if (sx < 0) begin
            cx    <= -sx;
            cy    <= -sy;
            acc   <= 32'h80000000;
            state <= S_ID_ROT;
          end else begin
            cx    <= sx;
            cy    <= sy;
            acc   <= 32'h0;
            state <= S_ID_ROT;
          end
        end
        S_ID_ROT: begin
          if (cy >= 0) begin
            cx  <= cx + shy;
            cy  <= cy - shx;
            acc <= acc + atan_val(step);
          end else begin
            cx  <= cx - shy;
            cy  <= cy + shx;
            acc <= acc - atan_val(step);
          end
          step <= step + 1'b1;
          if (32'(step) == CORDIC_STEPS - 1) begin
            state <= S_ID_INS;
          end
        end
        S_ID_INS: begin
          for (int j = 0; j < MAX_DOTS; j++) begin
            ang[j] <= ang_ins[j];
            col[j] <= col_ins[j];
          end
          m     <= m + 1'b1;
          k     <= k + 1'b1;
          state <= S_ID_RD;
        end
        S_GP_INIT: begin
          gi       <= m - 1'b1;
          gj       <= '0;
          prev_ang <= ang[DI_W'(m - 1'b1)];
          state    <= S_GP_RUN;
        end
        S_GP_RUN: begin
          if (gap > wide_gap) begin
            wide_gap <= gap;
            best     <= gi;
          end
          prev_ang <= gap_ang;
          gi       <= gj;
          gj       <= gj + 1'b1;
          if (gj == m - 1'b1) begin
            rc    <= '0;
            state <= S_RT;
          end
        end
        S_RT: begin
          // Rotate the first m colors left by one until the leader is in front.
          if (rc == best) begin
            state <= S_PM_RD;
          end else begin
            for (int j = 0; j < MAX_DOTS; j++) begin
              if (j + 1 == 32'(m)) begin
                col[j] <= col[0];
              end else if (j + 1 < 32'(m)) begin
                col[j] <= col[(j + 1 < MAX_DOTS) ? j + 1 : 0];
              end
            end
            rc <= rc + 1'b1;
          end
        end
        S_PM_RD: begin
          if (LIM_W'(pk) >= limit) begin
            state <= S_DONE;
          end else begin
            state <= S_PM_CHK;
          end
        end
        S_PM_CHK: begin
          if (pat_ok) begin
            found    <= 1'b1;
            found_id <= PIDX_W'(pk);
            state    <= S_DONE;
          end else begin
            pk    <= pk + 1'b1;
            state <= S_PM_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_matched <= found && !overflow_flag;
            out_id      <= (found && !overflow_flag) ? found_id : 4'd0;
            out_count   <= 4'(m);
            out_ovf     <= overflow_flag;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The dot count never passes the store depth.
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    32'(kept_count) <= MAX_DOTS) else $error("kept dot count beyond store depth");

  // Sorted dots never outnumber kept blobs while an identify word is in work.
  a_sorted_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_BL_MUL && state != S_BL_CMP) |-> m <= kept_count)
    else $error("sorted list longer than kept dots");

  // An overflowed marker is never reported as matched.
  a_ovf_nomatch: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ovf |-> !out_matched) else $error("match reported on overflow");

  // An identify word starts the dot walk on the next cycle.
  a_ident_start: assert property (@(posedge clk) disable iff (rst)
    req_acc && req_type_t'(req.req_type) == REQ_IDENT |=> state == S_ID_RD)
    else $error("identify did not start the dot walk");

endmodule

@@ src/mdpi_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module mdpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
